>>> hw/rtl/mbdf_pkg.sv
// ----------------------------------------------------------------------------
// mbdf_pkg
// Shared types and constants for the 2x2 box downsampler with fade.
// ----------------------------------------------------------------------------
package mbdf_pkg;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] REG_SOURCE_WIDTH      = 3'd0;
   localparam logic [2:0] REG_SOURCE_HEIGHT     = 3'd1;
   localparam logic [2:0] REG_TINT_WORD         = 3'd2;
   localparam logic [2:0] REG_BLEND_WEIGHT      = 3'd3;
   localparam logic [2:0] REG_TINT_RGB_EN       = 3'd4;
   localparam logic [2:0] REG_FADE_ALPHA_ENABLE = 3'd5;

   localparam logic [8:0] FULL_WEIGHT = 9'd256;

   typedef struct packed {
      logic [7:0] in_alpha;
      logic [7:0] in_chan2;
      logic [7:0] in_chan1;
      logic [7:0] in_chan0;
   } pixel_in_type;

   typedef struct packed {
      logic       out_frame_end;
      logic       out_row_end;
      logic [7:0] out_alpha;
      logic [7:0] out_chan2;
      logic [7:0] out_chan1;
      logic [7:0] out_chan0;
   } pixel_out_type;

   typedef struct packed {
      logic [12:0] source_width;
      logic [12:0] source_height;
      logic [31:0] tint_word;
      logic [8:0]  blend_weight;
      logic        tint_rgb_en;
      logic        fade_alpha_enable;
   } cfg_type;

   // 2x2 block sums, index 0..2 color channels, 3 alpha
   typedef struct packed {
      logic            row_end;
      logic            frame_end;
      logic [3:0][9:0] sum;
   } blk_sum_type;

   function automatic logic [7:0] sat8(input logic [8:0] v);
      logic [7:0] r;
      r = v[8] ? 8'hFF : v[7:0];
      return r;
   endfunction

endpackage

>>> hw/rtl/mip_box_downsample_fade.sv
// ----------------------------------------------------------------------------
// mip_box_downsample_fade
// 2x2 box-filter mipmap downsampler with optional fade toward a color.
//
//   channel   ports          direction  moves
//   req       push / full    in         one source pixel word
//   rsp       pop / empty    out        one downsampled pixel word
//   csr       APB-style      in         configuration registers
//
// One source pixel is accepted every clock while req_full is low; one result per 2x2 block.
// The line store is read at the edge that accepts a block's last source word;
// the result then passes through the queue, multiply and output registers.
// A 4-entry queue decouples pixel intake from the blend pipeline;
// req_full rises only after the output stalls and the queue fills.
// Reset is synchronous; the line store needs no clearing.
// ----------------------------------------------------------------------------
module mip_box_downsample_fade #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  mbdf_pkg::pixel_in_type              req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output mbdf_pkg::pixel_out_type             rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mbdf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mbdf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mbdf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   mbdf_pkg::cfg_type     cfg;
   mbdf_pkg::blk_sum_type q_push_data, q_pop_data;
   logic                  q_push, q_full, q_pop, q_empty;

   mbdf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mbdf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_push_data)
   );

   mbdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   mbdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_data    (q_pop_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/mbdf_csr.sv
// ----------------------------------------------------------------------------
// mbdf_csr
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module mbdf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mbdf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mbdf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mbdf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output mbdf_pkg::cfg_type                   cfg
);

   mbdf_pkg::cfg_type cfg_ff;
   mbdf_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            mbdf_pkg::REG_SOURCE_WIDTH:      cfg_in.source_width      = csr_pwdata[12:0];
            mbdf_pkg::REG_SOURCE_HEIGHT:     cfg_in.source_height     = csr_pwdata[12:0];
            mbdf_pkg::REG_TINT_WORD:         cfg_in.tint_word         = csr_pwdata;
            mbdf_pkg::REG_BLEND_WEIGHT:      cfg_in.blend_weight      = csr_pwdata[8:0];
            mbdf_pkg::REG_TINT_RGB_EN:       cfg_in.tint_rgb_en       = csr_pwdata[0];
            mbdf_pkg::REG_FADE_ALPHA_ENABLE: cfg_in.fade_alpha_enable = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         mbdf_pkg::REG_SOURCE_WIDTH:      csr_prdata = {19'd0, cfg_ff.source_width};
         mbdf_pkg::REG_SOURCE_HEIGHT:     csr_prdata = {19'd0, cfg_ff.source_height};
         mbdf_pkg::REG_TINT_WORD:         csr_prdata = cfg_ff.tint_word;
         mbdf_pkg::REG_BLEND_WEIGHT:      csr_prdata = {23'd0, cfg_ff.blend_weight};
         mbdf_pkg::REG_TINT_RGB_EN:       csr_prdata = {31'd0, cfg_ff.tint_rgb_en};
         mbdf_pkg::REG_FADE_ALPHA_ENABLE: csr_prdata = {31'd0, cfg_ff.fade_alpha_enable};
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width      <= 13'd2;
         cfg_ff.source_height     <= 13'd2;
         cfg_ff.tint_word         <= '0;
         cfg_ff.blend_weight      <= '0;
         cfg_ff.tint_rgb_en       <= 1'b0;
         cfg_ff.fade_alpha_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/mbdf_front.sv
// ----------------------------------------------------------------------------
// mbdf_front
// Raster position tracking, horizontal pair sums and the pair-sum line store.
// Emits one 2x2 block sum for each odd-row, odd-column source pixel.
// ----------------------------------------------------------------------------
module mbdf_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mbdf_pkg::cfg_type      cfg,
   input  logic                   req_push,
   output logic                   req_full,
   input  mbdf_pkg::pixel_in_type req_data,
   output logic                   q_push,
   input  logic                   q_full,
   output mbdf_pkg::blk_sum_type  q_data
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int RW         = $clog2(MAX_HEIGHT);
   localparam int LD         = MAX_WIDTH / 2;
   localparam int AW         = $clog2(LD);
   localparam int W_LAST_MAX = (MAX_WIDTH / 2) * 2 - 1;
   localparam int H_LAST_MAX = (MAX_HEIGHT / 2) * 2 - 1;

   logic [CW-1:0]       col_ff, col_in, col_last;
   logic [RW-1:0]       row_ff, row_in, row_last;
   logic [3:0][7:0]     hold_ff;
   logic [3:0][7:0]     px;
   logic [3:0][8:0]     pair;
   logic [35:0]         line_mem [LD];
   logic [3:0][8:0]     rd_ff;
   logic [AW-1:0]       idx;
   logic                acc, is_last_col, is_last_row, line_wr, line_rd;
   logic                f1_valid_ff, f1_valid_in;
   logic [3:0][8:0]     f1_pair_ff;
   logic                f1_row_end_ff, f1_frame_end_ff;

   always_comb begin
      if (cfg.source_width < 13'd2) begin
         col_last = CW'(1);
      end else if (32'(cfg.source_width) > MAX_WIDTH) begin
         col_last = CW'(W_LAST_MAX);
      end else begin
         col_last = CW'({19'd0, cfg.source_width[12:1], 1'b0} - 32'd1);
      end
      if (cfg.source_height < 13'd2) begin
         row_last = RW'(1);
      end else if (32'(cfg.source_height) > MAX_HEIGHT) begin
         row_last = RW'(H_LAST_MAX);
      end else begin
         row_last = RW'({19'd0, cfg.source_height[12:1], 1'b0} - 32'd1);
      end
   end

   assign req_full    = f1_valid_ff & q_full;
   assign acc         = req_push & ~req_full;
   assign is_last_col = col_ff >= col_last;
   assign is_last_row = row_ff >= row_last;
   assign idx         = col_ff[AW:1];
   assign line_wr     = acc & col_ff[0] & ~row_ff[0];
   assign line_rd     = acc & col_ff[0] & row_ff[0];
   assign px          = {req_data.in_alpha, req_data.in_chan2,
                         req_data.in_chan1, req_data.in_chan0};

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         pair[c] = {1'b0, hold_ff[c]} + {1'b0, px[c]};
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (is_last_col) begin
            col_in = '0;
            row_in = is_last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign q_push      = f1_valid_ff & ~q_full;
   assign f1_valid_in = acc ? line_rd : (f1_valid_ff & q_full);

   always_comb begin
      q_data.row_end   = f1_row_end_ff;
      q_data.frame_end = f1_frame_end_ff;
      for (int c = 0; c < 4; c++) begin
         q_data.sum[c] = {1'b0, f1_pair_ff[c]} + {1'b0, rd_ff[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_mem[idx] <= pair;
      end
      if (line_rd) begin
         rd_ff <= line_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         if (!col_ff[0]) begin
            hold_ff <= px;
         end
         f1_pair_ff      <= pair;
         f1_row_end_ff   <= is_last_col;
         f1_frame_end_ff <= is_last_col & is_last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

endmodule

>>> hw/rtl/mbdf_queue.sv
// ----------------------------------------------------------------------------
// mbdf_queue
// Short FIFO of block sums between the front and the blend pipeline.
// ----------------------------------------------------------------------------
module mbdf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mbdf_pkg::blk_sum_type push_data,
   output logic                  full,
   input  logic                  pop,
   output mbdf_pkg::blk_sum_type pop_data,
   output logic                  empty
);

   localparam int PW = $clog2(mbdf_pkg::QUEUE_DEPTH);

   mbdf_pkg::blk_sum_type slot_ff [mbdf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = count_ff == (PW+1)'(mbdf_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/mbdf_back.sv
// ----------------------------------------------------------------------------
// mbdf_back
// Fade blend, alpha 9/8 scale and saturation; multiply stage then output
// register.
// ----------------------------------------------------------------------------
module mbdf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mbdf_pkg::cfg_type       cfg,
   input  mbdf_pkg::blk_sum_type   q_data,
   input  logic                    q_empty,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output mbdf_pkg::pixel_out_type rsp_data
);

   logic [8:0]       w, wc_color, wc_alpha;
   logic [3:0][8:0]  wc, inv;
   logic [3:0][7:0]  m;
   logic [3:0][18:0] prod_a;
   logic [3:0][16:0] prod_b;
   logic [3:0][18:0] b1_a_ff;
   logic [3:0][16:0] b1_b_ff;
   logic             b1_row_end_ff, b1_frame_end_ff;
   logic             b1_valid_ff, b1_valid_in;
   logic             out_valid_ff, out_valid_in;
   mbdf_pkg::pixel_out_type out_ff, out_in;
   logic [3:0][18:0] n;
   logic [21:0]      n9;
   logic             out_take, b1_move, b1_load;

   assign w        = (cfg.blend_weight > mbdf_pkg::FULL_WEIGHT) ?
                     mbdf_pkg::FULL_WEIGHT : cfg.blend_weight;
   assign wc_color = cfg.tint_rgb_en ? w : 9'd0;
   assign wc_alpha = cfg.fade_alpha_enable ? w : 9'd0;
   assign m        = {cfg.tint_word[31:24], cfg.tint_word[7:0],
                      cfg.tint_word[15:8], cfg.tint_word[23:16]};
   assign wc       = {wc_alpha, wc_color, wc_color, wc_color};

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         inv[c]    = mbdf_pkg::FULL_WEIGHT - wc[c];
         prod_a[c] = 19'(q_data.sum[c]) * 19'(inv[c]);
         prod_b[c] = 17'(m[c]) * 17'(wc[c]);
      end
   end

   assign out_take     = rsp_pop & out_valid_ff;
   assign b1_move      = b1_valid_ff & (~out_valid_ff | out_take);
   assign b1_load      = ~b1_valid_ff | b1_move;
   assign q_pop        = b1_load & ~q_empty;
   assign b1_valid_in  = q_pop | (b1_valid_ff & ~b1_move);
   assign out_valid_in = b1_move | (out_valid_ff & ~out_take);
   assign rsp_empty    = ~out_valid_ff;
   assign rsp_data     = out_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         n[c] = b1_a_ff[c] + {b1_b_ff[c], 2'b00};
      end
      n9                   = {n[3], 3'b000} + {3'b000, n[3]};
      out_in.out_chan0     = mbdf_pkg::sat8(n[0][18:10]);
      out_in.out_chan1     = mbdf_pkg::sat8(n[1][18:10]);
      out_in.out_chan2     = mbdf_pkg::sat8(n[2][18:10]);
      out_in.out_alpha     = mbdf_pkg::sat8(n9[21:13]);
      out_in.out_row_end   = b1_row_end_ff;
      out_in.out_frame_end = b1_frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_a_ff         <= prod_a;
         b1_b_ff         <= prod_b;
         b1_row_end_ff   <= q_data.row_end;
         b1_frame_end_ff <= q_data.frame_end;
      end
      if (b1_move) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> hw/rtl/mbdf_checker.sv
// ----------------------------------------------------------------------------
// mbdf_checker
// Port-level checks for the box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module mbdf_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_full,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input mbdf_pkg::pixel_out_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("not idle after reset");

   a_frame_ends_row: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (!rsp_data.out_frame_end || rsp_data.out_row_end))
      else $error("frame end without row end");

   a_full_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled with no result waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind mip_box_downsample_fade mbdf_checker u_mbdf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

>>> sim/tb_mip_box_downsample_fade.sv
// ----------------------------------------------------------------------------
// tb_mip_box_downsample_fade
// Self-checking bench for the 2x2 box downsampler with fade. A scoreboard
// tracks the line store, the column and row position and the register copy,
// predicts every downsampled word from the accepted source words and checks
// the result words in order. Directed frames come first. Random phases
// follow, with random configuration between phases and four sender and
// receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_mip_box_downsample_fade;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM    = 4096;
   localparam int LINE_DEPTH = MAX_DIM / 2;
   localparam int LIMIT      = 500000;
   localparam int SETTLE     = 8;

   class downsample_scoreboard;
      logic [35:0] pair_sums [LINE_DEPTH];
      bit          written [LINE_DEPTH];
      logic [31:0] left_hold;
      int unsigned col, row;
      logic [12:0] width_cfg, height_cfg;
      logic [31:0] fade_cfg;
      logic [8:0]  weight_cfg;
      bit          color_en_cfg, alpha_en_cfg;
      mbdf_pkg::pixel_out_type pending[$];
      int err_count;
      int seen_count;

      function new();
         left_hold = '0;
         col = 0;
         row = 0;
         width_cfg = 13'd2;
         height_cfg = 13'd2;
         fade_cfg = '0;
         weight_cfg = '0;
         color_en_cfg = 0;
         alpha_en_cfg = 0;
         err_count = 0;
         seen_count = 0;
      endfunction

      function void flag(string msg);
         err_count++;
         if (err_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
         end
      endfunction

      function int unsigned eff_dim(logic [12:0] v);
         int unsigned r;
         r = 32'(v);
         if (r < 2) r = 2;
         if (r > MAX_DIM) r = MAX_DIM;
         return r & ~32'd1;
      endfunction

      // a new width must not make the odd row read a line entry never written
      function bit width_ok(logic [12:0] v);
         int unsigned half;
         half = eff_dim(v) / 2;
         if (row % 2 == 0 && col == 0) return 1;
         for (int i = 0; i < half; i++) begin
            if (!written[i]) return 0;
         end
         return 1;
      endfunction

      function int waiting();
         return pending.size();
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            mbdf_pkg::REG_SOURCE_WIDTH:      width_cfg = v[12:0];
            mbdf_pkg::REG_SOURCE_HEIGHT:     height_cfg = v[12:0];
            mbdf_pkg::REG_TINT_WORD:         fade_cfg = v;
            mbdf_pkg::REG_BLEND_WEIGHT:      weight_cfg = v[8:0];
            mbdf_pkg::REG_TINT_RGB_EN:       color_en_cfg = v[0];
            mbdf_pkg::REG_FADE_ALPHA_ENABLE: alpha_en_cfg = v[0];
            default: ;
         endcase
      endfunction

      function void take_pixel(mbdf_pkg::pixel_in_type px);
         int unsigned ew, eh, idx, s, m, wc, n, q, w;
         bit last_col, last_row;
         logic [8:0] pr [4];
         logic [7:0] ch [4];
         logic [31:0] bits_in;
         mbdf_pkg::pixel_out_type want;
         bits_in = px;
         ew = eff_dim(width_cfg);
         eh = eff_dim(height_cfg);
         last_col = col >= ew - 1;
         last_row = row >= eh - 1;
         idx = (col >> 1) % LINE_DEPTH;
         if (col % 2 == 0) begin
            left_hold = bits_in;
         end else begin
            for (int c = 0; c < 4; c++) begin
               pr[c] = {1'b0, left_hold[8*c +: 8]} + {1'b0, bits_in[8*c +: 8]};
            end
            if (row % 2 == 0) begin
               pair_sums[idx] = {pr[3], pr[2], pr[1], pr[0]};
               written[idx] = 1;
            end else begin
               w = (weight_cfg > mbdf_pkg::FULL_WEIGHT) ?
                   32'(mbdf_pkg::FULL_WEIGHT) : 32'(weight_cfg);
               for (int c = 0; c < 4; c++) begin
                  s = 32'(pr[c]) + 32'(pair_sums[idx][9*c +: 9]);
                  m = (c < 3) ? 32'(fade_cfg[16 - 8*c +: 8]) : 32'(fade_cfg[31:24]);
                  wc = ((c < 3) ? color_en_cfg : alpha_en_cfg) ? w : 0;
                  n = s * (256 - wc) + 4 * m * wc;
                  q = (c < 3) ? n / 1024 : (9 * n) / 8192;
                  ch[c] = (q > 255) ? 8'd255 : q[7:0];
               end
               want.out_chan0 = ch[0];
               want.out_chan1 = ch[1];
               want.out_chan2 = ch[2];
               want.out_alpha = ch[3];
               want.out_row_end = last_col;
               want.out_frame_end = last_col && last_row;
               pending.push_back(want);
            end
         end
         if (last_col) begin
            col = 0;
            row = last_row ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void match_output(mbdf_pkg::pixel_out_type got);
         mbdf_pkg::pixel_out_type want;
         string bad;
         seen_count++;
         if (pending.size() == 0) begin
            flag($sformatf("word %0d unexpected: c0=%0d c1=%0d c2=%0d a=%0d re=%0b fe=%0b",
                           seen_count, got.out_chan0, got.out_chan1, got.out_chan2,
                           got.out_alpha, got.out_row_end, got.out_frame_end));
            return;
         end
         want = pending.pop_front();
         bad = "";
         if (got.out_chan0 !== want.out_chan0) bad = {bad, " chan0"};
         if (got.out_chan1 !== want.out_chan1) bad = {bad, " chan1"};
         if (got.out_chan2 !== want.out_chan2) bad = {bad, " chan2"};
         if (got.out_alpha !== want.out_alpha) bad = {bad, " alpha"};
         if (got.out_row_end !== want.out_row_end) bad = {bad, " row_end"};
         if (got.out_frame_end !== want.out_frame_end) bad = {bad, " frame_end"};
         if (bad != "") begin
            flag($sformatf({"word %0d bad%s: exp c0=%0d c1=%0d c2=%0d a=%0d re=%0b fe=%0b",
                            " got c0=%0d c1=%0d c2=%0d a=%0d re=%0b fe=%0b"},
                           seen_count, bad, want.out_chan0, want.out_chan1,
                           want.out_chan2, want.out_alpha, want.out_row_end,
                           want.out_frame_end, got.out_chan0, got.out_chan1,
                           got.out_chan2, got.out_alpha, got.out_row_end,
                           got.out_frame_end));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   mbdf_pkg::pixel_in_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   mbdf_pkg::pixel_out_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [mbdf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [mbdf_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [mbdf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   downsample_scoreboard sb;
   mbdf_pkg::pixel_in_type pixel_feed[$];
   int gap_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   mip_box_downsample_fade uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT) begin
         $display("mip_box_downsample_fade: mismatch");
         $finish;
      end
   end

   // result side
   initial begin
      forever begin
         @(negedge clock);
         rsp_pop <= !reset && ($urandom_range(99) >= stall_pct);
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            sb.match_output(rsp_data);
         end
      end
   end

   function automatic mbdf_pkg::pixel_in_type random_pixel();
      logic [7:0] b [4];
      for (int c = 0; c < 4; c++) begin
         case ($urandom_range(7))
            0: b[c] = 8'h00;
            1: b[c] = 8'hFF;
            default: b[c] = 8'($urandom_range(255));
         endcase
      end
      return {b[3], b[2], b[1], b[0]};
   endfunction

   task automatic program_reg(logic [2:0] idx, logic [31:0] v);
      logic [31:0] mask;
      case (idx)
         mbdf_pkg::REG_SOURCE_WIDTH, mbdf_pkg::REG_SOURCE_HEIGHT: mask = 32'h1FFF;
         mbdf_pkg::REG_BLEND_WEIGHT: mask = 32'h1FF;
         mbdf_pkg::REG_TINT_RGB_EN, mbdf_pkg::REG_FADE_ALPHA_ENABLE: mask = 32'h1;
         default: mask = 32'hFFFF_FFFF;
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (v & mask)) begin
         sb.flag($sformatf("register %0d reads %h, wrote %h", idx, csr_prdata, v & mask));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   task automatic feed_pixels();
      while (pixel_feed.size() != 0) begin
         @(negedge clock);
         if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            req_push <= 1'b0;
         end else begin
            req_push <= 1'b1;
            req_data <= pixel_feed[0];
         end
         @(posedge clock);
         if (req_push && !req_full) begin
            sb.take_pixel(req_data);
            void'(pixel_feed.pop_front());
         end
      end
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   task automatic settle();
      while (sb.waiting() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      repeat (count) pixel_feed.push_back(random_pixel());
   endtask

   task automatic shuffle_config(bit all_regs);
      logic [12:0] w, h;
      if (all_regs || $urandom_range(1)) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: w = 13'(2 * $urandom_range(1, 12));
            7: w = 13'(2 * $urandom_range(1, 12) + 1);
            8: begin
               case ($urandom_range(3))
                  0: w = 13'd0;
                  1: w = 13'd1;
                  2: w = 13'd8191;
                  default: w = 13'($urandom_range(4097, 8190));
               endcase
            end
            default: w = 13'($urandom_range(2, 64));
         endcase
         if (sb.width_ok(w)) program_reg(mbdf_pkg::REG_SOURCE_WIDTH, 32'(w));
      end
      if (all_regs || $urandom_range(1)) begin
         case ($urandom_range(7))
            0: h = 13'd0;
            1: h = 13'd1;
            2: h = ($urandom_range(1)) ? 13'd8191 : 13'd4096;
            3: h = 13'(2 * $urandom_range(1, 5) + 1);
            default: h = 13'(2 * $urandom_range(1, 6));
         endcase
         program_reg(mbdf_pkg::REG_SOURCE_HEIGHT, 32'(h));
      end
      if (all_regs || $urandom_range(1)) begin
         case ($urandom_range(3))
            0: program_reg(mbdf_pkg::REG_TINT_WORD, 32'h0);
            1: program_reg(mbdf_pkg::REG_TINT_WORD, 32'hFFFF_FFFF);
            default: program_reg(mbdf_pkg::REG_TINT_WORD, $urandom());
         endcase
      end
      if (all_regs || $urandom_range(1)) begin
         case ($urandom_range(9))
            0: program_reg(mbdf_pkg::REG_BLEND_WEIGHT, 32'd0);
            1: program_reg(mbdf_pkg::REG_BLEND_WEIGHT, 32'(mbdf_pkg::FULL_WEIGHT));
            2: program_reg(mbdf_pkg::REG_BLEND_WEIGHT, $urandom_range(257, 511));
            default: program_reg(mbdf_pkg::REG_BLEND_WEIGHT, $urandom_range(0, 256));
         endcase
      end
      if (all_regs || $urandom_range(1)) begin
         program_reg(mbdf_pkg::REG_TINT_RGB_EN, $urandom_range(1));
      end
      if (all_regs || $urandom_range(1)) begin
         program_reg(mbdf_pkg::REG_FADE_ALPHA_ENABLE, $urandom_range(1));
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // out-of-range sizes act as 2x2; full-scale words saturate
      program_reg(mbdf_pkg::REG_SOURCE_WIDTH, 32'd1);
      program_reg(mbdf_pkg::REG_SOURCE_HEIGHT, 32'd0);
      program_reg(mbdf_pkg::REG_TINT_WORD, 32'h0);
      program_reg(mbdf_pkg::REG_BLEND_WEIGHT, 32'd0);
      program_reg(mbdf_pkg::REG_TINT_RGB_EN, 32'd0);
      program_reg(mbdf_pkg::REG_FADE_ALPHA_ENABLE, 32'd0);
      repeat (4) pixel_feed.push_back({4{8'hFF}});
      repeat (4) pixel_feed.push_back({4{8'h00}});
      feed_pixels();
      settle();

      // full fade weight returns the fade color; alpha is the fade alpha scaled by 9/8 and saturated
      program_reg(mbdf_pkg::REG_TINT_WORD, 32'hE380_FF01);
      program_reg(mbdf_pkg::REG_BLEND_WEIGHT, 32'(mbdf_pkg::FULL_WEIGHT));
      program_reg(mbdf_pkg::REG_TINT_RGB_EN, 32'd1);
      program_reg(mbdf_pkg::REG_FADE_ALPHA_ENABLE, 32'd1);
      queue_random(4);
      feed_pixels();
      settle();

      // weight past full scale clamps
      program_reg(mbdf_pkg::REG_BLEND_WEIGHT, 32'd511);
      queue_random(4);
      feed_pixels();
      settle();

      // odd sizes round down, half blend on color only
      program_reg(mbdf_pkg::REG_SOURCE_WIDTH, 32'd5);
      program_reg(mbdf_pkg::REG_SOURCE_HEIGHT, 32'd3);
      program_reg(mbdf_pkg::REG_BLEND_WEIGHT, 32'd128);
      program_reg(mbdf_pkg::REG_FADE_ALPHA_ENABLE, 32'd0);
      queue_random(8);
      feed_pixels();
      settle();

      for (int phase = 0; phase < 20; phase++) begin
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 73; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 73; end
            default: begin gap_pct = 31; stall_pct = 31; end
         endcase
         shuffle_config(phase == 0);
         queue_random($urandom_range(40, 120));
         feed_pixels();
         settle();
      end

      if (sb.err_count == 0) begin
         $display("mip_box_downsample_fade: match");
      end else begin
         $display("mip_box_downsample_fade: mismatch");
      end
      $finish;
   end

endmodule
